// ===== hw/rtl/fan_speed_step_regulator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fan speed step regulator
// Shared clocked assertion forms, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_STEP_REGULATOR_MACROS_SVH
`define FAN_SPEED_STEP_REGULATOR_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define FSSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FSSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fssr_pkg.sv =====
// ----------------------------------------------------------------------------
// fssr_pkg
// Types and constants shared by the fan speed step regulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fssr_pkg;

    localparam int SPEED_WIDTH_DEF = 16;
    localparam int FAIL_TICKS_DEF  = 10;

    localparam int DUTY_W  = 7;
    localparam int STALL_W = 4;

    // error thresholds
    localparam int ERR_UP_BIG = 300;
    localparam int ERR_UP     = 80;
    localparam int ERR_DN_BIG = 100;
    localparam int ERR_DN     = 80;

    // duty steps and limits
    localparam logic [DUTY_W-1:0] DUTY_STEP_BIG = 7'd20;
    localparam logic [DUTY_W-1:0] DUTY_STEP     = 7'd3;
    localparam logic [DUTY_W-1:0] DUTY_STEP_DN  = 7'd3;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_DN_MIN   = 7'd5;
    localparam logic [DUTY_W-1:0] DUTY_FLOOR    = 7'd10;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [STALL_W-1:0] stall_ticks;
        logic               fail;
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/fssr_step.sv =====
// ----------------------------------------------------------------------------
// fssr_step
// One regulation tick: duty step, stall counting and sticky fail flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fssr_step #(
    parameter int SPEED_WIDTH = fssr_pkg::SPEED_WIDTH_DEF,
    parameter int FAIL_TICKS  = fssr_pkg::FAIL_TICKS_DEF
) (
    input  wire logic [SPEED_WIDTH-1:0] i_target_speed,
    input  wire logic [SPEED_WIDTH-1:0] i_pulse_count,
    input  wire logic                   i_pwm_high,
    input  wire logic                   i_clear_fail,
    input  wire fssr_pkg::t_state       i_state,
    output fssr_pkg::t_state            o_state,
    output logic                        o_duty_written
);
    import fssr_pkg::*;

    // error wide enough for the thresholds at any speed width
    localparam int ERR_W = (SPEED_WIDTH + 1 > 11) ? SPEED_WIDTH + 1 : 11;
    localparam int EXT_W = ERR_W - SPEED_WIDTH;

    localparam logic signed [ERR_W-1:0] LIM_UP_BIG = ERR_W'(ERR_UP_BIG);
    localparam logic signed [ERR_W-1:0] LIM_UP     = ERR_W'(ERR_UP);
    localparam logic signed [ERR_W-1:0] LIM_DN_BIG = ERR_W'(-ERR_DN_BIG);
    localparam logic signed [ERR_W-1:0] LIM_DN     = ERR_W'(-ERR_DN);
    localparam logic [STALL_W-1:0]      STALL_LIM  = STALL_W'(FAIL_TICKS);

    logic signed [ERR_W-1:0] err;
    logic [DUTY_W:0]         up_sum;
    logic [DUTY_W-1:0]       n_duty;
    logic [DUTY_W-1:0]       adj_duty;
    logic                    regulate;
    logic                    fail_clr;

    assign err = $signed({{EXT_W{1'b0}}, i_target_speed})
               - $signed({{EXT_W{1'b0}}, i_pulse_count});

    always_comb begin
        up_sum = {1'b0, i_state.duty};
        n_duty = i_state.duty;
        if (err > $signed(ERR_W'(0))) begin
            if (err > LIM_UP_BIG) begin
                up_sum = {1'b0, i_state.duty} + {1'b0, DUTY_STEP_BIG};
            end else if (err > LIM_UP) begin
                up_sum = {1'b0, i_state.duty} + {1'b0, DUTY_STEP};
            end
            // cap at max duty
            if (up_sum > {1'b0, DUTY_MAX}) begin
                n_duty = DUTY_MAX;
            end else begin
                n_duty = up_sum[DUTY_W-1:0];
            end
        end else if (err < LIM_DN_BIG) begin
            if (i_state.duty > DUTY_DN_MIN) begin
                n_duty = i_state.duty - DUTY_STEP_DN;
            end
        end else if (err < LIM_DN) begin
            if (i_state.duty != '0) begin
                n_duty = i_state.duty - DUTY_W'(1);
            end
        end
        adj_duty = (n_duty < DUTY_FLOOR) ? DUTY_FLOOR : n_duty;
    end

    assign regulate = (i_target_speed != '0) && i_pwm_high;

    always_comb begin
        fail_clr       = i_state.fail & ~i_clear_fail;
        o_state        = i_state;
        o_state.fail   = fail_clr;
        o_duty_written = 1'b0;
        if (i_target_speed != '0) begin
            if (regulate) begin
                o_state.duty   = adj_duty;
                o_duty_written = 1'b1;
                if (i_pulse_count == '0) begin
                    if (i_state.stall_ticks >= STALL_LIM) begin
                        o_state.stall_ticks = '0;
                        o_state.fail        = 1'b1;
                    end else begin
                        o_state.stall_ticks = i_state.stall_ticks + STALL_W'(1);
                    end
                end else begin
                    o_state.stall_ticks = '0;
                end
            end else begin
                o_state.stall_ticks = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fan_speed_step_regulator.sv =====
// ----------------------------------------------------------------------------
// fan_speed_step_regulator
// Per-tick step regulator for fan PWM duty with stall detection.
// ----------------------------------------------------------------------------
// One request per control tick enters an input register; the step logic
// then updates duty, stall count and fail flag and loads the result register
// when that register is free or draining. A request is taken every cycle
// unless the input register is held by a stalled result register. The duty
// feedback loop closes through the step logic and the state register. The
// user must write target_speed through the configuration port only while no
// request is in flight; the block itself does not enforce this. Zero powers
// the motor off and freezes regulation.
`default_nettype none

module fan_speed_step_regulator #(
    parameter int SPEED_WIDTH = fssr_pkg::SPEED_WIDTH_DEF,
    parameter int FAIL_TICKS  = fssr_pkg::FAIL_TICKS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [SPEED_WIDTH-1:0]   i_cfg_target_speed,
    // request channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [SPEED_WIDTH-1:0]   i_pulse_count,
    input  wire logic                     i_pwm_high,
    input  wire logic                     i_clear_fail,
    // result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [fssr_pkg::DUTY_W-1:0]   o_pwm_duty,
    output logic                          o_duty_written,
    output logic                          o_fail,
    output logic                          o_power_on
);
    import fssr_pkg::*;

    logic [SPEED_WIDTH-1:0] r_target_speed;

    logic                   r_in_valid;
    logic [SPEED_WIDTH-1:0] r_pulse_count;
    logic                   r_pwm_high;
    logic                   r_clear_fail;

    t_state                 r_state;
    t_state                 n_state;
    logic                   n_written;

    logic                   r_out_valid;
    logic [DUTY_W-1:0]      r_pwm_duty;
    logic                   r_duty_written;
    logic                   r_fail;
    logic                   r_power_on;

    logic                   advance;
    logic                   in_take;

    assign o_cfg_ready = 1'b1;

    // advance the input stage when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target_speed <= i_cfg_target_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pulse_count <= i_pulse_count;
            r_pwm_high    <= i_pwm_high;
            r_clear_fail  <= i_clear_fail;
        end
    end

    fssr_step #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .FAIL_TICKS  (FAIL_TICKS)
    ) u_step (
        .i_target_speed (r_target_speed),
        .i_pulse_count  (r_pulse_count),
        .i_pwm_high     (r_pwm_high),
        .i_clear_fail   (r_clear_fail),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_duty_written (n_written)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pwm_duty     <= n_state.duty;
            r_duty_written <= n_written;
            r_fail         <= n_state.fail;
            r_power_on     <= (r_target_speed != '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pwm_duty     = r_pwm_duty;
    assign o_duty_written = r_duty_written;
    assign o_fail         = r_fail;
    assign o_power_on     = r_power_on;

endmodule

`default_nettype wire

// ===== hw/rtl/fssr_checker.sv =====
// ----------------------------------------------------------------------------
// fssr_checker
// Port-level checks for the fan speed step regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_speed_step_regulator_macros.svh"

module fssr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [fssr_pkg::DUTY_W-1:0] o_pwm_duty,
    input wire logic                        o_duty_written,
    input wire logic                        o_fail,
    input wire logic                        o_power_on
);
    import fssr_pkg::*;

    // a stalled result holds
    `FSSR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pwm_duty) && $stable(o_fail), "result changed while stalled")

    // no duty write with motor power off
    `FSSR_ASSERT(a_off_no_write, i_clk, i_rst_n, o_out_valid && !o_power_on |-> !o_duty_written, "duty written with zero target")

    // a written duty lies between floor and cap
    `FSSR_ASSERT(a_duty_range, i_clk, i_rst_n, o_out_valid && o_duty_written |-> (o_pwm_duty >= DUTY_FLOOR) && (o_pwm_duty <= DUTY_MAX), "written duty out of range")

    // no result right after reset
    `FSSR_ASSERT_ALWAYS(a_rst_idle, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid after reset")

endmodule

bind fan_speed_step_regulator fssr_checker u_fssr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pwm_duty     (o_pwm_duty),
    .o_duty_written (o_duty_written),
    .o_fail         (o_fail),
    .o_power_on     (o_power_on)
);

`default_nettype wire

// ===== tb/fan_speed_step_regulator_tb.sv =====
// ----------------------------------------------------------------------------
// fan_speed_step_regulator_tb
// Self-checking testbench for the fan speed step regulator. A scoreboard
// class predicts duty, write strobe, fail flag and power state for each
// accepted request and compares every accepted result in order. Directed
// requests hit the error thresholds, the stall counter and the fail clear;
// random phases follow with several target speeds and random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fan_speed_step_regulator_tb;

    localparam int SPEED_W      = 16;
    localparam int STALL_LIMIT  = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [fssr_pkg::DUTY_W-1:0] pwm_duty;
        logic                        duty_written;
        logic                        fail;
        logic                        power_on;
    } duty_result_t;

    class duty_scoreboard;
        logic [SPEED_W-1:0]           target;
        logic [fssr_pkg::DUTY_W-1:0]  duty;
        logic [3:0]                   zero_ticks;
        logic                         sticky_fail;
        duty_result_t                 pending[$];
        int                           errors;

        function new();
            target      = '0;
            duty        = '0;
            zero_ticks  = '0;
            sticky_fail = 1'b0;
            errors      = 0;
        endfunction

        function void set_target(logic [SPEED_W-1:0] value);
            target = value;
        endfunction

        // Step the regulator state for one request and queue its result.
        function void note_request(logic [SPEED_W-1:0] pulses, logic pin_high, logic clr);
            int           d;
            int           err;
            duty_result_t res;
            res.duty_written = 1'b0;
            if (clr)
                sticky_fail = 1'b0;
            if (target != 0) begin
                if (pin_high) begin
                    err = int'(target) - int'(pulses);
                    d   = int'(duty);
                    if (err > 0) begin
                        if (err > 300)
                            d += 20;
                        else if (err > 80)
                            d += 3;
                        if (d > 99)
                            d = 99;
                    end else if (err < -100) begin
                        if (d > 5)
                            d -= 3;
                    end else if (err < -80) begin
                        if (d > 0)
                            d -= 1;
                    end
                    if (d < 10)
                        d = 10;
                    duty = d[fssr_pkg::DUTY_W-1:0];
                    res.duty_written = 1'b1;
                    if (pulses == 0) begin
                        if (zero_ticks >= STALL_LIMIT) begin
                            zero_ticks  = '0;
                            sticky_fail = 1'b1;
                        end else begin
                            zero_ticks = zero_ticks + 4'd1;
                        end
                    end else begin
                        zero_ticks = '0;
                    end
                end else begin
                    zero_ticks = '0;
                end
            end
            res.pwm_duty = duty;
            res.fail     = sticky_fail;
            res.power_on = (target != 0);
            pending.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(duty_result_t got);
            duty_result_t exp;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending (duty %0d)", got.pwm_duty));
            end else begin
                exp = pending.pop_front();
                if (got.pwm_duty !== exp.pwm_duty)
                    report($sformatf("pwm_duty %0d, want %0d", got.pwm_duty, exp.pwm_duty));
                if (got.duty_written !== exp.duty_written)
                    report($sformatf("duty_written %0b, want %0b",
                                     got.duty_written, exp.duty_written));
                if (got.fail !== exp.fail)
                    report($sformatf("fail %0b, want %0b", got.fail, exp.fail));
                if (got.power_on !== exp.power_on)
                    report($sformatf("power_on %0b, want %0b", got.power_on, exp.power_on));
            end
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [SPEED_W-1:0]          i_cfg_target_speed;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [SPEED_W-1:0]          i_pulse_count;
    logic                        i_pwm_high;
    logic                        i_clear_fail;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [fssr_pkg::DUTY_W-1:0] o_pwm_duty;
    logic                        o_duty_written;
    logic                        o_fail;
    logic                        o_power_on;

    duty_scoreboard sb = new();

    bit              out_quiet;
    bit              in_quiet;
    int              stall_left;
    int              stall_roll;
    int              cycle_count;
    logic [SPEED_W-1:0] cur_target;

    fan_speed_step_regulator #(
        .SPEED_WIDTH (SPEED_W),
        .FAIL_TICKS  (STALL_LIMIT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_target_speed (i_cfg_target_speed),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_pulse_count      (i_pulse_count),
        .i_pwm_high         (i_pwm_high),
        .i_clear_fail       (i_clear_fail),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_pwm_duty         (o_pwm_duty),
        .o_duty_written     (o_duty_written),
        .o_fail             (o_fail),
        .o_power_on         (o_power_on)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_target_speed = '0;
        i_in_valid = 1'b0;
        i_pulse_count = '0;
        i_pwm_high = 1'b0;
        i_clear_fail = 1'b0;
        i_out_stall = 1'b0;
        out_quiet = 1'b0;
        in_quiet = 1'b0;
        stall_left = 0;
        cycle_count = 0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample both channels and the config port at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_pwm_duty, o_duty_written, o_fail, o_power_on});
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_pulse_count, i_pwm_high, i_clear_fail);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_target(i_cfg_target_speed);
        end
    end

    // Result-side backpressure: mostly short stalls, a few long ones.
    always @(negedge i_clk) begin
        if (out_quiet || !i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
                stall_left = $urandom_range(15, 50);
            else if (stall_roll < 25)
                stall_left = $urandom_range(0, 3);
            i_out_stall <= (stall_roll < 25);
        end
    end

    task automatic send_request(logic [SPEED_W-1:0] pulses, logic pin_high, logic clr);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_pulse_count <= pulses;
        i_pwm_high    <= pin_high;
        i_clear_fail  <= clr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Keep most pulse counts near the target so every step band is reached.
    function automatic logic [SPEED_W-1:0] pick_pulses(logic [SPEED_W-1:0] target);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 22)
            return SPEED_W'($urandom);
        v = int'(target) + int'($urandom_range(0, 800)) - 400;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[SPEED_W-1:0];
    endfunction

    task automatic wait_drained();
        idle_gap(1);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(logic [SPEED_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_target_speed <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_target = value;
    endtask

    initial begin
        int zero_run;
        int pin_roll;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: threshold edges around a target of 1000.
        write_target(16'd1000);
        // Ten zero-pulse ticks fill the stall count; the eleventh clears and
        // fails in the same tick, so the flag must end up set.
        repeat (10) send_request(16'd0, 1'b1, 1'b0);
        send_request(16'd0, 1'b1, 1'b1);
        send_request(16'd700, 1'b1, 1'b0);
        send_request(16'd699, 1'b1, 1'b0);
        send_request(16'd920, 1'b1, 1'b0);
        send_request(16'd919, 1'b1, 1'b0);
        send_request(16'd1080, 1'b1, 1'b0);
        send_request(16'd1081, 1'b1, 1'b0);
        send_request(16'd1100, 1'b1, 1'b0);
        send_request(16'd1101, 1'b1, 1'b0);
        send_request(16'hFFFF, 1'b1, 1'b0);
        send_request(16'd0, 1'b0, 1'b0);
        send_request(16'd1000, 1'b1, 1'b1);
        // Zero target: regulation frozen, clear still honored.
        write_target(16'd0);
        send_request(16'd0, 1'b1, 1'b0);
        send_request(16'hFFFF, 1'b1, 1'b1);

        zero_run = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_target(16'hFFFF);
                1: write_target(16'd0);
                2: write_target(16'd1);
                3: write_target(16'd100);
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        write_target(SPEED_W'($urandom_range(100, 3000)));
                    else
                        write_target(SPEED_W'($urandom));
                end
            endcase
            in_quiet  = (p % 3 == 2);
            out_quiet = (p % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off mid-phase until the pipe is empty.
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                if (zero_run == 0 && $urandom_range(0, 99) < 3)
                    zero_run = $urandom_range(5, 14);
                pin_roll = $urandom_range(0, 99);
                if (zero_run > 0) begin
                    zero_run--;
                    send_request('0, (pin_roll < 95), ($urandom_range(0, 19) == 0));
                end else begin
                    send_request(pick_pulses(cur_target), (pin_roll < 80),
                                 ($urandom_range(0, 9) == 0));
                end
                idle_gap(pick_gap());
            end
        end

        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
